[rtl/pfe_pkg.sv]
package pfe_pkg;

  // one palette entry, 8 bits per channel
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // command codes
  localparam logic [2:0] OP_WR_TARGET  = 3'd0;
  localparam logic [2:0] OP_WR_CURRENT = 3'd1;
  localparam logic [2:0] OP_START      = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  // effect codes on the start command
  localparam logic [1:0] FX_FADE_IN   = 2'd0;
  localparam logic [1:0] FX_FADE_OUT  = 2'd1;
  localparam logic [1:0] FX_FLASH_IN  = 2'd2;
  localparam logic [1:0] FX_FLASH_OUT = 2'd3;

  // running effect
  typedef enum logic [2:0] {
    EFF_IDLE      = 3'd0,
    EFF_FADE_IN   = 3'd1,
    EFF_FADE_OUT  = 3'd2,
    EFF_FLASH_IN  = 3'd3,
    EFF_FLASH_OUT = 3'd4
  } effect_t;

  localparam logic [7:0] STEP      = 8'd32;
  localparam logic [7:0] WHITE     = 8'd224;
  localparam logic [4:0] LAST_TICK = 5'd21;

  // blue first, then green, then red, toward target
  function automatic rgb_t rise_to_target(input rgb_t c, input rgb_t t);
    rgb_t n;
    n = c;
    if (t.b > c.b) n.b = c.b + STEP;
    else if (t.g > c.g) n.g = c.g + STEP;
    else if (t.r > c.r) n.r = c.r + STEP;
    return n;
  endfunction

  function automatic rgb_t fall_to_target(input rgb_t c, input rgb_t t);
    rgb_t n;
    n = c;
    if (t.b < c.b) n.b = c.b - STEP;
    else if (t.g < c.g) n.g = c.g - STEP;
    else if (t.r < c.r) n.r = c.r - STEP;
    return n;
  endfunction

  // red first, then green, then blue
  function automatic rgb_t drop_to_black(input rgb_t c);
    rgb_t n;
    n = c;
    if (c.r != 8'd0) n.r = c.r - STEP;
    else if (c.g != 8'd0) n.g = c.g - STEP;
    else if (c.b != 8'd0) n.b = c.b - STEP;
    return n;
  endfunction

  function automatic rgb_t rise_to_white(input rgb_t c);
    rgb_t n;
    n = c;
    if (c.r != WHITE) n.r = c.r + STEP;
    else if (c.g != WHITE) n.g = c.g + STEP;
    else if (c.b != WHITE) n.b = c.b + STEP;
    return n;
  endfunction

endpackage

[rtl/palette_fade_engine_top.sv]
// Palette fade engine. A command is taken when start is high and busy is low; every
// command gives exactly one result, shown for one cycle with strobe high, and the
// receiver cannot stall it. Writes, starts of fade-out and flash-out, unknown opcodes
// and ticks while idle answer in the next cycle; a read first waits in S_READ.
// A fade-in or flash-in start fills its layer-0 range at one entry per cycle. A tick
// during an effect walks its range through the current/target memories at one entry
// per cycle, writing each entry back after its registered read. After reset a clearing
// pass zeroes both palettes while busy stays high; configuration writes are taken at
// any time.
module palette_fade_engine_top #(
  parameter int ENTRIES_PER_LAYER = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic       layer,
  input  logic [5:0] entry_index,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [1:0] effect,
  output logic       strobe,
  output logic       done_res,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);
  import pfe_pkg::*;

  localparam int DEPTH = 2 * ENTRIES_PER_LAYER;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(ENTRIES_PER_LAYER);
  localparam int CW    = ((EW > 6) ? EW : 6) + 1;
  localparam logic [AW-1:0] LAYER_BASE = AW'(ENTRIES_PER_LAYER);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] LAST_ENT_C = CW'(ENTRIES_PER_LAYER - 1);
  localparam logic [EW-1:0] LAST_ENT   = EW'(ENTRIES_PER_LAYER - 1);

  localparam logic [1:0] CFG_FIRST  = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_LAYER2 = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_FILL  = 5'b01000,
    S_STEP  = 5'b10000
  } state_t;

  state_t        state;
  effect_t       active;
  logic [4:0]    frame_count;
  logic [5:0]    first_entry;
  logic [5:0]    range_last_offset;
  logic          second_layer_enable;

  logic [AW-1:0] clr_addr;
  logic [EW-1:0] ent;
  logic [EW-1:0] lo_ent;
  logic [EW-1:0] hi_ent;
  logic          lay;
  logic          both;
  logic          issuing;
  logic          wb_pend;
  logic [AW-1:0] wb_addr;
  logic          rd_ok;
  rgb_t          fill_val;

  rgb_t          cur_mem [DEPTH];
  rgb_t          tgt_mem [DEPTH];
  rgb_t          cur_rd;
  rgb_t          tgt_rd;

  // fade-in span from configuration, clipped at the last entry
  logic [CW-1:0] span_sum;
  logic [CW-1:0] span_hi;
  logic [CW-1:0] span_lo;
  logic          span_empty;

  always_comb begin
    span_sum   = CW'(first_entry) + CW'(range_last_offset);
    span_hi    = (span_sum > LAST_ENT_C) ? LAST_ENT_C : span_sum;
    span_lo    = CW'(first_entry);
    span_empty = span_lo > span_hi;
  end

  // command decode
  logic          accept;
  logic          idx_ok;
  logic [AW-1:0] slot;
  logic [AW-1:0] sweep_addr;
  logic [4:0]    fc_inc;
  logic          tick_over;
  rgb_t          in_rgb;

  always_comb begin
    accept     = start && (state == S_IDLE);
    idx_ok     = CW'(entry_index) < CW'(ENTRIES_PER_LAYER);
    slot       = (layer ? LAYER_BASE : AW'(0)) + AW'(entry_index);
    sweep_addr = (lay ? LAYER_BASE : AW'(0)) + AW'(ent);
    fc_inc     = frame_count + 5'd1;
    tick_over  = fc_inc > LAST_TICK;
    in_rgb     = '{r: red_in, g: green_in, b: blue_in};
  end

  // new value of the entry coming back from memory
  rgb_t step_rgb;

  always_comb begin
    unique case (active)
      EFF_FADE_IN:   step_rgb = rise_to_target(cur_rd, tgt_rd);
      EFF_FADE_OUT:  step_rgb = drop_to_black(cur_rd);
      EFF_FLASH_IN:  step_rgb = fall_to_target(cur_rd, tgt_rd);
      EFF_FLASH_OUT: step_rgb = rise_to_white(cur_rd);
      default:       step_rgb = cur_rd;
    endcase
  end

  // memory port selection
  logic          cur_we;
  logic          tgt_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  rgb_t          cur_wd;
  rgb_t          tgt_wd;

  always_comb begin
    cur_we = 1'b0;
    tgt_we = 1'b0;
    mem_wa = slot;
    mem_ra = sweep_addr;
    cur_wd = in_rgb;
    tgt_wd = in_rgb;
    unique case (state)
      S_CLEAR: begin
        cur_we = 1'b1;
        tgt_we = 1'b1;
        mem_wa = clr_addr;
        cur_wd = '0;
        tgt_wd = '0;
      end
      S_IDLE: begin
        mem_ra = slot;
        cur_we = accept && (opcode == OP_WR_CURRENT) && idx_ok;
        tgt_we = accept && (opcode == OP_WR_TARGET) && idx_ok;
      end
      S_FILL: begin
        cur_we = 1'b1;
        mem_wa = AW'(ent);
        cur_wd = fill_val;
      end
      S_STEP: begin
        cur_we = wb_pend;
        mem_wa = wb_addr;
        cur_wd = step_rgb;
      end
      default: begin
        cur_we = 1'b0;
      end
    endcase
  end

  // palette memories, registered read
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[mem_wa] <= cur_wd;
    cur_rd <= cur_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[mem_wa] <= tgt_wd;
    tgt_rd <= tgt_mem[mem_ra];
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_CLEAR;
      active              <= EFF_IDLE;
      frame_count         <= 5'd0;
      first_entry         <= 6'd0;
      range_last_offset   <= 6'd63;
      second_layer_enable <= 1'b1;
      clr_addr            <= '0;
      issuing             <= 1'b0;
      wb_pend             <= 1'b0;
      strobe              <= 1'b0;
    end else begin
      strobe <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST:  first_entry <= cfg_data;
          CFG_OFFSET: range_last_offset <= cfg_data;
          CFG_LAYER2: second_layer_enable <= cfg_data[0];
          default:    ;
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) state <= S_IDLE;
        end

        S_IDLE: begin
          if (accept) begin
            done_res  <= 1'b0;
            red_out   <= 8'd0;
            green_out <= 8'd0;
            blue_out  <= 8'd0;
            unique case (opcode)
              OP_START: begin
                frame_count <= 5'd0;
                unique case (effect)
                  FX_FADE_IN: begin
                    active   <= EFF_FADE_IN;
                    fill_val <= '0;
                    ent      <= span_lo[EW-1:0];
                    hi_ent   <= span_hi[EW-1:0];
                    if (span_empty) strobe <= 1'b1;
                    else state <= S_FILL;
                  end
                  FX_FADE_OUT: begin
                    active <= EFF_FADE_OUT;
                    strobe <= 1'b1;
                  end
                  FX_FLASH_IN: begin
                    active   <= EFF_FLASH_IN;
                    fill_val <= '{r: WHITE, g: WHITE, b: WHITE};
                    ent      <= '0;
                    hi_ent   <= LAST_ENT;
                    state    <= S_FILL;
                  end
                  default: begin
                    active <= EFF_FLASH_OUT;
                    strobe <= 1'b1;
                  end
                endcase
              end
              OP_TICK: begin
                if (active == EFF_IDLE) begin
                  strobe   <= 1'b1;
                  done_res <= 1'b1;
                end else if ((active == EFF_FADE_IN) && span_empty) begin
                  // nothing to step, only the frame count moves and the effect may end
                  strobe <= 1'b1;
                  if (tick_over) begin
                    frame_count <= 5'd0;
                    active      <= EFF_IDLE;
                    done_res    <= 1'b1;
                  end else begin
                    frame_count <= fc_inc;
                  end
                end else begin
                  if (active == EFF_FADE_IN) begin
                    ent    <= span_lo[EW-1:0];
                    lo_ent <= span_lo[EW-1:0];
                    hi_ent <= span_hi[EW-1:0];
                  end else begin
                    ent    <= '0;
                    lo_ent <= '0;
                    hi_ent <= LAST_ENT;
                  end
                  both    <= (active == EFF_FADE_OUT) || (active == EFF_FLASH_OUT) ||
                             second_layer_enable;
                  lay     <= 1'b0;
                  issuing <= 1'b1;
                  wb_pend <= 1'b0;
                  state   <= S_STEP;
                end
              end
              OP_READ: begin
                rd_ok <= idx_ok;
                state <= S_READ;
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end

        S_READ: begin
          strobe    <= 1'b1;
          red_out   <= rd_ok ? cur_rd.r : 8'd0;
          green_out <= rd_ok ? cur_rd.g : 8'd0;
          blue_out  <= rd_ok ? cur_rd.b : 8'd0;
          state     <= S_IDLE;
        end

        S_FILL: begin
          ent <= ent + EW'(1);
          if (ent == hi_ent) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end

        S_STEP: begin
          // read one entry per cycle, write back the previous one
          if (issuing) begin
            wb_pend <= 1'b1;
            wb_addr <= sweep_addr;
            if (ent == hi_ent) begin
              if (!lay && both) begin
                lay <= 1'b1;
                ent <= lo_ent;
              end else begin
                issuing <= 1'b0;
              end
            end else begin
              ent <= ent + EW'(1);
            end
          end else begin
            wb_pend <= 1'b0;
          end
          // last write-back closes the tick
          if (!issuing && wb_pend) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
            if (tick_over) begin
              frame_count <= 5'd0;
              active      <= EFF_IDLE;
              done_res    <= 1'b1;
            end else begin
              frame_count <= fc_inc;
              done_res    <= 1'b0;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/pfe_checker.sv]
module pfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] opcode,
  input logic       strobe,
  input logic       done_res,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);
  import pfe_pkg::*;

  // reset starts the clearing pass with no result pending
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !strobe)
    else $error("busy or strobe wrong after reset");

  // palette writes answer in the next cycle and leave the unit free
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == OP_WR_TARGET || opcode == OP_WR_CURRENT)
    |=> strobe && !busy && !done_res)
    else $error("write transfer without next-cycle result");

  // a read holds the unit busy while it waits on memory
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_READ |=> busy && !strobe)
    else $error("read transfer not waiting on memory");

  // a done report never carries color data
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && done_res |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("done result with color data");

  // no result without a command in flight or just taken
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy || start))
    else $error("result with no command");

endmodule

bind palette_fade_engine_top pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .opcode    (opcode),
  .strobe    (strobe),
  .done_res  (done_res),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out)
);
